// ----- hdl/urd_pkg.sv -----
// shared types and constants for the utf-8 rune decoder
package urd_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 3;
    localparam int unsigned CpW    = 21;
    localparam int unsigned SizeW  = 3;
    localparam int unsigned StatW  = 3;

    localparam logic [CountW-1:0] MaxCount = 3'd5;

    localparam logic [ByteW-1:0] ContMask  = 8'hC0;
    localparam logic [ByteW-1:0] ContTag   = 8'h80;
    localparam logic [ByteW-1:0] Lead3Min  = 8'hE0;
    localparam logic [ByteW-1:0] Lead4Min  = 8'hF0;
    localparam logic [ByteW-1:0] Cont3Min  = 8'hA0;
    localparam logic [ByteW-1:0] Cont4Min  = 8'h90;

    localparam logic [CpW-1:0] Min2 = 21'h000080;
    localparam logic [CpW-1:0] Min3 = 21'h000800;
    localparam logic [CpW-1:0] Min4 = 21'h010000;
    localparam logic [CpW-1:0] SurLo = 21'h00D800;
    localparam logic [CpW-1:0] SurHi = 21'h00DFFF;
    localparam logic [CpW-1:0] CpMax = 21'h10FFFF;

    typedef enum logic [StatW-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_BADLEN    = 3'd2,
        ST_BADCONT   = 3'd3,
        ST_OVERLONG  = 3'd4,
        ST_SURROGATE = 3'd5,
        ST_TOOBIG    = 3'd6,
        ST_BADLEAD   = 3'd7
    } t_status;

    typedef struct packed {
        logic [ByteW-1:0]  lead_byte;
        logic [ByteW-1:0]  second_byte;
        logic [ByteW-1:0]  third_byte;
        logic [ByteW-1:0]  fourth_byte;
        logic [ByteW-1:0]  fifth_byte;
        logic [CountW-1:0] avail_count;
    } t_window;

    // after lead classification and length / continuation checks
    typedef struct packed {
        t_status          status;
        logic [SizeW-1:0] need;
        logic [ByteW-1:0] lead;
        logic [ByteW-1:0] b1;
        logic [5:0]       b2;
        logic [5:0]       b3;
    } t_lead_res;

    // after code point assembly and overlong check
    typedef struct packed {
        t_status          status;
        logic [SizeW-1:0] need;
        logic [CpW-1:0]   cp;
    } t_merge_res;

    function automatic logic is_cont(input logic [ByteW-1:0] b);
        return (b & ContMask) == ContTag;
    endfunction

endpackage

// ----- hdl/urd_if.sv -----
// request and result channel interfaces of the utf-8 rune decoder
interface urd_in_if;
    logic                               valid;
    logic                               ready;
    logic [urd_pkg::ByteW-1:0]          lead_byte;
    logic [urd_pkg::ByteW-1:0]          second_byte;
    logic [urd_pkg::ByteW-1:0]          third_byte;
    logic [urd_pkg::ByteW-1:0]          fourth_byte;
    logic [urd_pkg::ByteW-1:0]          fifth_byte;
    logic [urd_pkg::CountW-1:0]         avail_count;

    modport source (output valid, lead_byte, second_byte, third_byte, fourth_byte,
                    fifth_byte, avail_count, input ready);
    modport sink   (input valid, lead_byte, second_byte, third_byte, fourth_byte,
                    fifth_byte, avail_count, output ready);
endinterface

interface urd_out_if;
    logic                               valid;
    logic                               ready;
    logic [urd_pkg::CpW-1:0]            code_point;
    logic [urd_pkg::SizeW-1:0]          seq_size;
    logic [urd_pkg::StatW-1:0]          status;

    modport source (output valid, code_point, seq_size, status, input ready);
    modport sink   (input valid, code_point, seq_size, status, output ready);
endinterface

// ----- hdl/urd_lead.sv -----
// stage 1: lead byte class, length and continuation checks
module urd_lead (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  urd_pkg::t_window   i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output urd_pkg::t_lead_res o_data
);
    logic                          r_valid;
    urd_pkg::t_lead_res            r_data;
    urd_pkg::t_lead_res            n_data;
    logic [urd_pkg::CountW-1:0]    n_cnt;
    logic [urd_pkg::SizeW-1:0]     n_need;
    logic                          n_badlead;
    logic [urd_pkg::ByteW-1:0]     n_after;
    logic                          n_badlen;
    logic                          n_badcont;

    always_comb begin
        n_cnt = (i_data.avail_count > urd_pkg::MaxCount) ? urd_pkg::MaxCount
                                                         : i_data.avail_count;
        n_badlead = 1'b0;
        n_need    = 3'd1;
        if (i_data.lead_byte[7] == 1'b0) begin
            n_need = 3'd1;
        end else if (i_data.lead_byte[7:5] == 3'b110) begin
            n_need = 3'd2;
        end else if (i_data.lead_byte[7:4] == 4'b1110) begin
            n_need = 3'd3;
        end else if (i_data.lead_byte[7:3] == 5'b11110) begin
            n_need = 3'd4;
        end else begin
            n_badlead = 1'b1;
        end

        // byte right after the sequence
        unique case (n_need)
            3'd1:    n_after = i_data.second_byte;
            3'd2:    n_after = i_data.third_byte;
            3'd3:    n_after = i_data.fourth_byte;
            default: n_after = i_data.fifth_byte;
        endcase

        n_badlen = (n_cnt < n_need) ||
                   ((n_cnt > n_need) && urd_pkg::is_cont(n_after));

        n_badcont = ((n_need >= 3'd2) && !urd_pkg::is_cont(i_data.second_byte)) ||
                    ((n_need >= 3'd3) && !urd_pkg::is_cont(i_data.third_byte))  ||
                    ((n_need == 3'd4) && !urd_pkg::is_cont(i_data.fourth_byte));

        if (n_cnt == '0) begin
            n_data.status = urd_pkg::ST_EMPTY;
        end else if (n_badlead) begin
            n_data.status = urd_pkg::ST_BADLEAD;
        end else if (n_badlen) begin
            n_data.status = urd_pkg::ST_BADLEN;
        end else if (n_badcont) begin
            n_data.status = urd_pkg::ST_BADCONT;
        end else begin
            n_data.status = urd_pkg::ST_OK;
        end
        n_data.need = n_need;
        n_data.lead = i_data.lead_byte;
        n_data.b1   = i_data.second_byte;
        n_data.b2   = i_data.third_byte[5:0];
        n_data.b3   = i_data.fourth_byte[5:0];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ----- hdl/urd_merge.sv -----
// stage 2: code point assembly and overlong check
module urd_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  urd_pkg::t_lead_res  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output urd_pkg::t_merge_res o_data
);
    logic                      r_valid;
    urd_pkg::t_merge_res       r_data;
    urd_pkg::t_merge_res       n_data;
    logic [urd_pkg::CpW-1:0]   n_cp;
    logic                      n_overlong;

    always_comb begin
        unique case (i_data.need)
            3'd1:    n_cp = {14'd0, i_data.lead[6:0]};
            3'd2:    n_cp = {10'd0, i_data.lead[4:0], i_data.b1[5:0]};
            3'd3:    n_cp = {5'd0, i_data.lead[3:0], i_data.b1[5:0], i_data.b2};
            default: n_cp = {i_data.lead[2:0], i_data.b1[5:0], i_data.b2, i_data.b3};
        endcase

        unique case (i_data.need)
            3'd2:    n_overlong = n_cp < urd_pkg::Min2;
            3'd3:    n_overlong = (n_cp < urd_pkg::Min3) ||
                                  ((i_data.lead == urd_pkg::Lead3Min) &&
                                   (i_data.b1 < urd_pkg::Cont3Min));
            3'd4:    n_overlong = (n_cp < urd_pkg::Min4) ||
                                  ((i_data.lead == urd_pkg::Lead4Min) &&
                                   (i_data.b1 < urd_pkg::Cont4Min));
            default: n_overlong = 1'b0;
        endcase

        n_data.need = i_data.need;
        n_data.cp   = n_cp;
        if (i_data.status == urd_pkg::ST_OK && n_overlong) begin
            n_data.status = urd_pkg::ST_OVERLONG;
        end else begin
            n_data.status = i_data.status;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ----- hdl/urd_final.sv -----
// stage 3: range checks, error zeroing and result register
module urd_final (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  urd_pkg::t_merge_res       i_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [urd_pkg::CpW-1:0]   o_code_point,
    output logic [urd_pkg::SizeW-1:0] o_seq_size,
    output logic [urd_pkg::StatW-1:0] o_status
);
    logic                        r_valid;
    logic [urd_pkg::CpW-1:0]     r_cp;
    logic [urd_pkg::SizeW-1:0]   r_size;
    urd_pkg::t_status            r_status;
    urd_pkg::t_status            n_status;

    always_comb begin
        if (i_data.status != urd_pkg::ST_OK) begin
            n_status = i_data.status;
        end else if ((i_data.cp >= urd_pkg::SurLo) && (i_data.cp <= urd_pkg::SurHi)) begin
            n_status = urd_pkg::ST_SURROGATE;
        end else if (i_data.cp > urd_pkg::CpMax) begin
            n_status = urd_pkg::ST_TOOBIG;
        end else begin
            n_status = urd_pkg::ST_OK;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_status <= n_status;
            r_cp     <= (n_status == urd_pkg::ST_OK) ? i_data.cp : '0;
            r_size   <= (n_status == urd_pkg::ST_OK) ? i_data.need : '0;
        end
    end

    assign o_valid      = r_valid;
    assign o_code_point = r_cp;
    assign o_seq_size   = r_size;
    assign o_status     = r_status;
endmodule

// ----- hdl/utf8_rune_decoder_unit.sv -----
// utf-8 rune decoder top level: three-stage decode pipeline
// path: an accepted request is registered in the lead, merge and final stages in
//   turn, and the final stage register drives the result on the output
// throughput: one request per cycle; every stage holds one request and moves on
//   as soon as the stage after it is empty or being drained
// reset: synchronous active-low i_rst_n clears all stage valid bits;
//   payload registers are not reset
module utf8_rune_decoder_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    urd_in_if.sink    i_req,
    urd_out_if.source o_rsp
);
    // window as seen by the first stage
    urd_pkg::t_window    w_win;

    // stage-to-stage handshake and payload
    logic                w_v1;
    logic                w_r1;
    urd_pkg::t_lead_res  w_d1;
    logic                w_v2;
    logic                w_r2;
    urd_pkg::t_merge_res w_d2;

    assign w_win.lead_byte   = i_req.lead_byte;
    assign w_win.second_byte = i_req.second_byte;
    assign w_win.third_byte  = i_req.third_byte;
    assign w_win.fourth_byte = i_req.fourth_byte;
    assign w_win.fifth_byte  = i_req.fifth_byte;
    assign w_win.avail_count = i_req.avail_count;

    // stage 1: lead class, count saturation, length / trailing / continuation checks
    urd_lead u_lead (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_data  (w_win),
        .o_valid (w_v1),
        .i_ready (w_r1),
        .o_data  (w_d1)
    );

    // stage 2: payload bits gathered into the code point, overlong forms flagged
    urd_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v1),
        .o_ready (w_r1),
        .i_data  (w_d1),
        .o_valid (w_v2),
        .i_ready (w_r2),
        .o_data  (w_d2)
    );

    // stage 3: surrogate and range checks; errors force code point and size to zero
    urd_final u_final (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_v2),
        .o_ready      (w_r2),
        .i_data       (w_d2),
        .o_valid      (o_rsp.valid),
        .i_ready      (o_rsp.ready),
        .o_code_point (o_rsp.code_point),
        .o_seq_size   (o_rsp.seq_size),
        .o_status     (o_rsp.status)
    );
endmodule

// ----- hdl/urd_checker.sv -----
// port-level assertions for the utf-8 rune decoder, bound to the top level
module urd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [urd_pkg::CpW-1:0]   i_code_point,
    input logic [urd_pkg::SizeW-1:0] i_seq_size,
    input logic [urd_pkg::StatW-1:0] i_status
);
    // a result held back keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_code_point) &&
        $stable(i_seq_size) && $stable(i_status))
        else $error("stalled result changed");

    // errors carry no code point and no size
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != urd_pkg::ST_OK) |->
        (i_code_point == '0) && (i_seq_size == '0))
        else $error("error result with nonzero fields");

    // a good result is a scalar value with a legal size
    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == urd_pkg::ST_OK) |->
        (i_seq_size != '0) && (i_seq_size <= 3'd4) && (i_code_point <= urd_pkg::CpMax) &&
        !((i_code_point >= urd_pkg::SurLo) && (i_code_point <= urd_pkg::SurHi)))
        else $error("ok result out of range");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("pipeline not empty after reset");

    // an idle output lets the input side take a request
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked while output idle");
endmodule

bind utf8_rune_decoder_unit urd_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_code_point (o_rsp.code_point),
    .i_seq_size   (o_rsp.seq_size),
    .i_status     (o_rsp.status)
);

// ----- test/urd_rune_checker.sv -----
// result checker for the utf-8 rune decoder: predicts each request and compares results
`timescale 1ns / 100ps

module urd_rune_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    urd_in_if         i_req_mon,
    urd_out_if        i_rsp_mon,
    input  logic      i_end_check,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked,
    output logic [7:0] o_status_seen
);

    typedef struct packed {
        logic [urd_pkg::CpW-1:0]   cp;
        logic [urd_pkg::SizeW-1:0] size;
        urd_pkg::t_status          st;
    } t_rune;

    t_rune      expected_runes[$];
    int         fail_count  = 0;
    int         checked     = 0;
    logic [7:0] status_seen = '0;
    bit         end_done    = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    function automatic logic cont_byte(input logic [urd_pkg::ByteW-1:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // decode the first sequence of a window, in the order the checks are specified
    function automatic t_rune decode_rune(input urd_pkg::t_window w);
        logic [urd_pkg::ByteW-1:0]  b [0:4];
        logic [urd_pkg::CountW-1:0] n;
        logic [urd_pkg::SizeW-1:0]  need;
        logic [urd_pkg::CpW-1:0]    cp;
        int                         i;
        t_rune                      r;
        r.cp   = '0;
        r.size = '0;
        r.st   = urd_pkg::ST_OK;
        b[0] = w.lead_byte;
        b[1] = w.second_byte;
        b[2] = w.third_byte;
        b[3] = w.fourth_byte;
        b[4] = w.fifth_byte;
        n = (w.avail_count > urd_pkg::MaxCount) ? urd_pkg::MaxCount : w.avail_count;
        if (n == 0) begin
            r.st = urd_pkg::ST_EMPTY;
            return r;
        end
        casez (b[0])
            8'b0???????: begin
                need = 3'd1;
                cp   = {14'd0, b[0][6:0]};
            end
            8'b110?????: begin
                need = 3'd2;
                cp   = {16'd0, b[0][4:0]};
            end
            8'b1110????: begin
                need = 3'd3;
                cp   = {17'd0, b[0][3:0]};
            end
            8'b11110???: begin
                need = 3'd4;
                cp   = {18'd0, b[0][2:0]};
            end
            default: begin
                r.st = urd_pkg::ST_BADLEAD;
                return r;
            end
        endcase
        if (n < need || (n > need && cont_byte(b[need]))) begin
            r.st = urd_pkg::ST_BADLEN;
            return r;
        end
        for (i = 1; i < need; i++) begin
            if (!cont_byte(b[i])) begin
                r.st = urd_pkg::ST_BADCONT;
                return r;
            end
            cp = {cp[urd_pkg::CpW-7:0], b[i][5:0]};
        end
        if ((need == 3'd2 && cp < urd_pkg::Min2) ||
            (need == 3'd3 && (cp < urd_pkg::Min3 ||
                              (b[0] == urd_pkg::Lead3Min && b[1] < urd_pkg::Cont3Min))) ||
            (need == 3'd4 && (cp < urd_pkg::Min4 ||
                              (b[0] == urd_pkg::Lead4Min && b[1] < urd_pkg::Cont4Min)))) begin
            r.st = urd_pkg::ST_OVERLONG;
            return r;
        end
        if (cp >= urd_pkg::SurLo && cp <= urd_pkg::SurHi) begin
            r.st = urd_pkg::ST_SURROGATE;
            return r;
        end
        if (cp > urd_pkg::CpMax) begin
            r.st = urd_pkg::ST_TOOBIG;
            return r;
        end
        r.cp   = cp;
        r.size = need;
        return r;
    endfunction

    always @(posedge i_clk) begin
        urd_pkg::t_window win;
        t_rune            want;
        if (i_rst_n) begin
            if (i_req_mon.valid && i_req_mon.ready) begin
                win.lead_byte   = i_req_mon.lead_byte;
                win.second_byte = i_req_mon.second_byte;
                win.third_byte  = i_req_mon.third_byte;
                win.fourth_byte = i_req_mon.fourth_byte;
                win.fifth_byte  = i_req_mon.fifth_byte;
                win.avail_count = i_req_mon.avail_count;
                expected_runes.push_back(decode_rune(win));
            end
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (expected_runes.size() == 0) begin
                    report_mismatch("unexpected result, status", i_rsp_mon.status, 0);
                end else begin
                    want = expected_runes.pop_front();
                    if (i_rsp_mon.code_point !== want.cp)
                        report_mismatch("code_point", i_rsp_mon.code_point, want.cp);
                    if (i_rsp_mon.seq_size !== want.size)
                        report_mismatch("seq_size", i_rsp_mon.seq_size, want.size);
                    if (i_rsp_mon.status !== want.st)
                        report_mismatch("status", i_rsp_mon.status, want.st);
                    checked++;
                    status_seen[want.st] = 1'b1;
                end
            end
            if (i_end_check && !end_done) begin
                end_done = 1'b1;
                if (expected_runes.size() != 0)
                    report_mismatch("results never delivered", expected_runes.size(), 0);
            end
        end
        o_fail_count  <= fail_count;
        o_pending     <= expected_runes.size();
        o_checked     <= checked;
        o_status_seen <= status_seen;
    end

endmodule

// ----- test/tb_utf8_rune_decoder_unit.sv -----
// top of the utf-8 rune decoder testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps

module tb_utf8_rune_decoder_unit;

    localparam int WatchdogLimit = 5000;  // idle cycles with no handshake at all
    localparam int LongHold      = 60;    // receiver hold-off that backs up the pipeline
    localparam int RandomCount   = 600;
    localparam int DrainCycles   = 8;     // extra wait once no result is pending

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic end_check;

    urd_in_if  req_ch ();
    urd_out_if rsp_ch ();

    int         fail_count;
    int         pending;
    int         checked;
    logic [7:0] status_seen;

    // shared knobs between the request and result sides
    bit bursts_on   = 1'b1;
    bit hold_wanted = 1'b0;
    bit hold_taken  = 1'b0;

    int sent_count     = 0;
    int directed_count = 0;
    int stall_cycles   = 0;

    utf8_rune_decoder_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    urd_rune_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_mon     (req_ch),
        .i_rsp_mon     (rsp_ch),
        .i_end_check   (end_check),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_status_seen (status_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog: any cycle without a handshake on either channel counts toward the limit
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WatchdogLimit) begin
                $display("watchdog: no handshake for %0d cycles", stall_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // offer one request and hold it until the block takes it;
    // valid stays high afterward so back-to-back requests need no extra edge
    task automatic send_bytes(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3,
                              input logic [7:0] b4, input logic [2:0] n);
        int gap;
        gap = (bursts_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.lead_byte   <= b0;
        req_ch.second_byte <= b1;
        req_ch.third_byte  <= b2;
        req_ch.fourth_byte <= b3;
        req_ch.fifth_byte  <= b4;
        req_ch.avail_count <= n;
        do @(posedge i_clk); while (!req_ch.ready);
        sent_count++;
    endtask

    // build a window around a randomly chosen code point; when damaged, one of:
    // a flipped bit, a cut-short window, a stray continuation byte after the
    // sequence, an overlong encoding, or a four-byte value above the unicode range
    task automatic send_random_rune(input bit damaged);
        int                      len;
        int                      mode;
        int                      k;
        int                      bitpos;
        int unsigned             lo;
        int unsigned             hi;
        int unsigned             raw;
        logic [urd_pkg::CpW-1:0] cp;
        logic [7:0]              b [0:4];
        logic [2:0]              n;
        len  = $urandom_range(1, 4);
        mode = damaged ? $urandom_range(0, 4) : 5;
        case (len)
            1:       begin lo = 'h0;     hi = 'h7F;     end
            2:       begin lo = 'h80;    hi = 'h7FF;    end
            3:       begin lo = 'h800;   hi = 'hFFFF;   end
            default: begin lo = 'h10000; hi = 'h10FFFF; end
        endcase
        // favor the range edges now and then
        case ($urandom_range(0, 9))
            0:       raw = lo;
            1:       raw = hi;
            default: raw = $urandom_range(lo, hi);
        endcase
        if (mode == 3 && len > 1)
            raw = $urandom_range(0, lo - 1);
        if (mode == 4) begin
            len = 4;
            raw = $urandom_range('h110000, 'h1FFFFF);
        end
        cp = raw[urd_pkg::CpW-1:0];
        case (len)
            1: b[0] = {1'b0, cp[6:0]};
            2: begin
                b[0] = {3'b110, cp[10:6]};
                b[1] = {2'b10, cp[5:0]};
            end
            3: begin
                b[0] = {4'b1110, cp[15:12]};
                b[1] = {2'b10, cp[11:6]};
                b[2] = {2'b10, cp[5:0]};
            end
            default: begin
                b[0] = {5'b11110, cp[20:18]};
                b[1] = {2'b10, cp[17:12]};
                b[2] = {2'b10, cp[11:6]};
                b[3] = {2'b10, cp[5:0]};
            end
        endcase
        // bytes after the sequence are mostly not continuations so the decode can pass
        for (k = len; k < 5; k++) begin
            b[k] = 8'($urandom_range(0, 255));
            if (b[k][7:6] == 2'b10 && $urandom_range(0, 3) != 0)
                b[k][6] = 1'b1;
        end
        n = 3'($urandom_range(len, 7));
        case (mode)
            0: begin
                k      = $urandom_range(0, len - 1);
                bitpos = $urandom_range(0, 7);
                b[k][bitpos] = ~b[k][bitpos];
            end
            1: n = 3'($urandom_range(0, len - 1));
            2: begin
                b[len] = {2'b10, 6'($urandom)};
                n      = 3'($urandom_range(len + 1, 7));
            end
            default: ;
        endcase
        send_bytes(b[0], b[1], b[2], b[3], b[4], n);
    endtask

    // result side: random stall bursts, plus one long hold-off on request
    initial begin : result_drain
        int hold;
        rsp_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_wanted && !hold_taken) begin
                hold_taken = 1'b1;
                rsp_ch.ready <= 1'b0;
                for (hold = 0; hold < LongHold; hold++) @(posedge i_clk);
            end else if (bursts_on && $urandom_range(0, 4) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin : request_stimulus
        int i;
        int pick;
        i_rst_n            <= 1'b0;
        end_check          <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.lead_byte   <= '0;
        req_ch.second_byte <= '0;
        req_ch.third_byte  <= '0;
        req_ch.fourth_byte <= '0;
        req_ch.fifth_byte  <= '0;
        req_ch.avail_count <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        // empty window, bytes ignored
        send_bytes(8'hFF, 8'h80, 8'h80, 8'h80, 8'h80, 3'd0);
        // plain ascii at both ends of its range
        send_bytes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1);
        send_bytes(8'h7F, 8'h41, 8'h80, 8'h80, 8'h80, 3'd5);
        // ascii followed by a stray continuation byte
        send_bytes(8'h41, 8'h80, 8'h00, 8'h00, 8'h00, 3'd2);
        // two-byte forms: smallest, largest, and overlong leads c0 / c1
        send_bytes(8'hC2, 8'h80, 8'h00, 8'h00, 8'h00, 3'd2);
        send_bytes(8'hDF, 8'hBF, 8'h20, 8'h00, 8'h00, 3'd3);
        send_bytes(8'hC0, 8'h80, 8'h00, 8'h00, 8'h00, 3'd2);
        send_bytes(8'hC1, 8'hBF, 8'h00, 8'h00, 8'h00, 3'd2);
        // three-byte forms around the overlong and surrogate edges
        send_bytes(8'hE0, 8'hA0, 8'h80, 8'h00, 8'h00, 3'd3);
        send_bytes(8'hE0, 8'h9F, 8'hBF, 8'h00, 8'h00, 3'd3);
        send_bytes(8'hED, 8'h9F, 8'hBF, 8'h00, 8'h00, 3'd3);
        send_bytes(8'hED, 8'hA0, 8'h80, 8'h00, 8'h00, 3'd3);
        send_bytes(8'hEF, 8'hBF, 8'hBF, 8'h7F, 8'h00, 3'd4);
        // four-byte forms: smallest, overlong, largest, and beyond the range
        send_bytes(8'hF0, 8'h90, 8'h80, 8'h80, 8'h00, 3'd4);
        send_bytes(8'hF0, 8'h8F, 8'hBF, 8'hBF, 8'h00, 3'd4);
        send_bytes(8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hC0, 3'd5);
        send_bytes(8'hF4, 8'h90, 8'h80, 8'h80, 8'h00, 3'd4);
        // leads f5..f7 decode as four-byte and land above the range
        send_bytes(8'hF5, 8'h80, 8'h80, 8'h80, 8'h00, 3'd4);
        send_bytes(8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00, 3'd4);
        // invalid leads: bare continuations and f8..ff
        send_bytes(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1);
        send_bytes(8'hBF, 8'h00, 8'h00, 8'h00, 8'h00, 3'd5);
        send_bytes(8'hF8, 8'h80, 8'h80, 8'h80, 8'h80, 3'd5);
        send_bytes(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1);
        // too few bytes, then a non-continuation inside the sequence
        send_bytes(8'hE2, 8'h82, 8'hAC, 8'h00, 8'h00, 3'd2);
        send_bytes(8'hE2, 8'h41, 8'hAC, 8'h00, 8'h00, 3'd3);
        // trailing continuation wins over a bad inner byte
        send_bytes(8'hC2, 8'h41, 8'h80, 8'h00, 8'h00, 3'd3);
        // counts six and seven behave as five
        send_bytes(8'hF0, 8'h90, 8'h80, 8'h80, 8'h41, 3'd7);
        send_bytes(8'hF0, 8'h90, 8'h80, 8'h80, 8'h80, 3'd6);
        directed_count = sent_count;

        // random part: mostly well-formed windows, some damaged, some pure noise
        for (i = 0; i < RandomCount; i++) begin
            if (i == 100)
                hold_wanted = 1'b1;  // sender keeps offering while the result side holds off
            if (i == 250)
                bursts_on = 1'b0;
            if (i == 300)
                bursts_on = 1'b1;
            if (i == 480)
                bursts_on = 1'b0;    // closing stretch at full rate on both sides
            pick = $urandom_range(0, 99);
            if (pick < 65)
                send_random_rune(1'b0);
            else if (pick < 85)
                send_random_rune(1'b1);
            else
                send_bytes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom), 3'($urandom_range(0, 7)));
        end
        req_ch.valid <= 1'b0;

        // drain: wait for every outstanding result, then a little longer
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);

        $display("run covered %0d requests (%0d directed), %0d results compared",
                 sent_count, directed_count, checked);
        $display("status codes produced, one bit per code: %b", status_seen);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
